// ----- src/nip_pkg.sv -----
package nip_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
   localparam logic [2:0] MSG_FIELD_LIMIT = 3'd4;
   localparam logic [2:0] HMSG_FIELD_LIMIT = 3'd5;
   localparam logic [2:0] VERB_LEN_MAX = 3'd7;

   localparam logic [31:0] W_PING = 32'h50494E47;
   localparam logic [31:0] W_PONG = 32'h504F4E47;
   localparam logic [31:0] W_ERR = 32'h2D455252;
   localparam logic [31:0] W_INFO = 32'h494E464F;
   localparam logic [31:0] W_HMSG = 32'h484D5347;
   localparam logic [31:0] W_OK = 32'h002B4F4B;
   localparam logic [31:0] W_MSG = 32'h004D5347;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   typedef enum logic [3:0] {
      PH_VERB, PH_SKIP, PH_ARG_LEAD, PH_ARG, PH_FIELDS,
      PH_HEADER, PH_PAYLOAD, PH_TERM_A, PH_TERM_B
   } phase_type;

   typedef enum logic [2:0] {
      RG_VERB, RG_BLANK, RG_FIELD, RG_ARG, RG_HDR, RG_PAY, RG_TERM, RG_IGN
   } region_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_PING, OP_PONG, OP_OK, OP_ERR, OP_INFO, OP_MSG, OP_UNKNOWN
   } op_type;

   typedef struct packed {
      logic [7:0] data;
      logic       blank;
      logic       cr;
      logic       lf;
      logic       digit;
   } front_item_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      region_type  region;
      logic [2:0]  field_number;
      logic        op_done;
      op_type      op_code;
      logic        has_reply;
      logic        has_headers;
      logic [31:0] hdr_count;
      logic [31:0] payload_bytes;
      logic        malformed;
   } rsp_item_type;

   typedef struct packed {
      op_type    op;
      phase_type ph;
   } verb_decision_type;

   function automatic verb_decision_type decide_verb(logic [31:0] vs, logic [2:0] vl);
      verb_decision_type d;
      d.op = OP_UNKNOWN;
      d.ph = PH_SKIP;
      if (vl == 3'd4) begin
         if (vs == W_PING) d.op = OP_PING;
         else if (vs == W_PONG) d.op = OP_PONG;
         else if (vs == W_ERR) begin
            d.op = OP_ERR;
            d.ph = PH_ARG_LEAD;
         end else if (vs == W_INFO) begin
            d.op = OP_INFO;
            d.ph = PH_ARG_LEAD;
         end else if (vs == W_HMSG) begin
            d.op = OP_MSG;
            d.ph = PH_FIELDS;
         end
      end else if (vl == 3'd3) begin
         if (vs == W_OK) d.op = OP_OK;
         else if (vs == W_MSG) begin
            d.op = OP_MSG;
            d.ph = PH_FIELDS;
         end
      end
      return d;
   endfunction

endpackage

// ----- src/nip_queue.sv -----
module nip_queue #(
   parameter type item_type = logic [7:0]
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);
   item_type   mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff ^ do_push;
      rd_in = rd_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

// ----- src/nip_front.sv -----
module nip_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              data_byte,
   output logic                    full,
   input  logic                    pop,
   output nip_pkg::front_item_type item,
   output logic                    empty
);
   import nip_pkg::*;

   front_item_type cls;

   // tag each octet on entry so the parser sees ready-made flags
   always_comb begin
      cls.data = data_byte;
      cls.blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB);
      cls.cr = (data_byte == CH_CR);
      cls.lf = (data_byte == CH_LF);
      cls.digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   end

   nip_queue #(.item_type(front_item_type)) u_inq (
      .clock(clock), .reset(reset),
      .push(push), .push_item(cls), .full(full),
      .pop(pop), .pop_item(item), .empty(empty)
   );

endmodule

// ----- src/nip_back.sv -----
module nip_back #(
   parameter int COUNT_WIDTH = nip_pkg::COUNT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [31:0]             csr_wdata,
   input  logic                    in_empty,
   input  nip_pkg::front_item_type in_item,
   output logic                    in_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output nip_pkg::rsp_item_type   out_item
);
   import nip_pkg::*;

   localparam int EW = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

   phase_type              phase_ff, phase_in;
   logic [31:0]            verb_shift_ff, verb_shift_in;
   logic [2:0]             verb_length_ff, verb_length_in;
   logic                   pending_cr_ff, pending_cr_in;
   logic                   inside_field_ff, inside_field_in;
   logic [2:0]             field_total_ff, field_total_in;
   logic [COUNT_WIDTH-1:0] fv0_ff, fv0_in, fv1_ff, fv1_in;
   logic                   ok0_ff, ok0_in, ok1_ff, ok1_in;
   logic [COUNT_WIDTH-1:0] header_left_ff, header_left_in;
   logic [COUNT_WIDTH-1:0] body_left_ff, body_left_in;
   op_type                 op_ff, op_in;
   logic [31:0]            max_payload_ff;

   logic                   go;
   logic                   handled, body_out, clear_line, accept;
   logic [2:0]             lim;
   logic [COUNT_WIDTH+3:0] prod;
   logic [COUNT_WIDTH-1:0] total, hdr;
   logic [EW-1:0]          total_x, max_x, fv0_x, fv1_x;
   verb_decision_type      dv;

   assign go = !in_empty && !out_full;
   assign in_pop = go;
   assign out_push = go;

   always_comb begin
      phase_in = phase_ff;
      verb_shift_in = verb_shift_ff;
      verb_length_in = verb_length_ff;
      pending_cr_in = pending_cr_ff;
      inside_field_in = inside_field_ff;
      field_total_in = field_total_ff;
      fv0_in = fv0_ff;
      fv1_in = fv1_ff;
      ok0_in = ok0_ff;
      ok1_in = ok1_ff;
      header_left_in = header_left_ff;
      body_left_in = body_left_ff;
      op_in = op_ff;
      handled = 1'b0;
      body_out = 1'b0;
      clear_line = 1'b0;
      accept = 1'b0;
      prod = '0;
      total = '0;
      hdr = '0;
      total_x = '0;
      max_x = EW'(max_payload_ff);
      fv0_x = '0;
      fv1_x = '0;
      dv = decide_verb(verb_shift_ff, verb_length_ff);
      lim = (verb_length_ff == 3'd4) ? HMSG_FIELD_LIMIT : MSG_FIELD_LIMIT;

      out_item = '0;
      out_item.echo_byte = in_item.data;

      if (phase_ff == PH_HEADER || phase_ff == PH_PAYLOAD ||
          phase_ff == PH_TERM_A || phase_ff == PH_TERM_B) begin
         body_out = 1'b1;
         unique case (phase_ff)
            PH_HEADER: begin
               out_item.region = RG_HDR;
               header_left_in = header_left_ff - COUNT_WIDTH'(1);
               if (header_left_in == '0)
                  phase_in = (body_left_ff != '0) ? PH_PAYLOAD : PH_TERM_A;
            end
            PH_PAYLOAD: begin
               out_item.region = RG_PAY;
               body_left_in = body_left_ff - COUNT_WIDTH'(1);
               if (body_left_in == '0) phase_in = PH_TERM_A;
            end
            PH_TERM_A: begin
               out_item.region = RG_TERM;
               phase_in = PH_TERM_B;
            end
            default: begin
               out_item.region = RG_TERM;
               out_item.op_done = 1'b1;
               clear_line = 1'b1;
            end
         endcase
      end else begin
         if (pending_cr_ff) begin
            pending_cr_in = 1'b0;
            if (in_item.lf) begin
               handled = 1'b1;
               out_item.region = RG_TERM;
               if (phase_in == PH_VERB) begin
                  dv = decide_verb(verb_shift_in, verb_length_in);
                  op_in = dv.op;
                  phase_in = dv.ph;
               end
            end else begin
               // a lone cr folds into the line as an ordinary octet
               case (phase_in)
                  PH_VERB: begin
                     verb_shift_in = {verb_shift_in[23:0], CH_CR};
                     if (verb_length_in < VERB_LEN_MAX) verb_length_in = verb_length_in + 3'd1;
                  end
                  PH_ARG_LEAD: phase_in = PH_ARG;
                  PH_FIELDS: begin
                     if (!inside_field_in) begin
                        if (field_total_in < lim) begin
                           fv1_in = fv0_in;
                           ok1_in = ok0_in;
                           fv0_in = '0;
                           ok0_in = 1'b0;
                           field_total_in = field_total_in + 3'd1;
                           inside_field_in = 1'b1;
                        end
                     end else begin
                        ok0_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         if (handled) begin
            // line end
            if (phase_in != PH_FIELDS) begin
               out_item.op_done = 1'b1;
               out_item.op_code = op_in;
               clear_line = 1'b1;
            end else begin
               total = fv0_in;
               hdr = (lim == HMSG_FIELD_LIMIT) ? fv1_in : '0;
               total_x = EW'(total);
               accept = (field_total_in == 3'(lim - 3'd1) || field_total_in == lim) && ok0_in &&
                        (lim != HMSG_FIELD_LIMIT || (ok1_in && hdr <= total)) &&
                        (total_x <= max_x);
               if (!accept) begin
                  out_item.op_done = 1'b1;
                  out_item.malformed = 1'b1;
                  clear_line = 1'b1;
               end else begin
                  inside_field_in = 1'b0;
                  fv1_in = hdr;
                  fv0_in = total - hdr;
                  header_left_in = hdr;
                  body_left_in = total - hdr;
                  if (hdr != '0) phase_in = PH_HEADER;
                  else if (total != hdr) phase_in = PH_PAYLOAD;
                  else phase_in = PH_TERM_A;
                  body_out = 1'b1;
               end
            end
         end else if (in_item.cr) begin
            pending_cr_in = 1'b1;
            out_item.region = RG_TERM;
            out_item.op_code = op_in;
         end else begin
            case (phase_in)
               PH_VERB: begin
                  if (in_item.blank) begin
                     dv = decide_verb(verb_shift_in, verb_length_in);
                     op_in = dv.op;
                     phase_in = dv.ph;
                     out_item.region = RG_BLANK;
                  end else begin
                     verb_shift_in = {verb_shift_in[23:0], in_item.data};
                     if (verb_length_in < VERB_LEN_MAX) verb_length_in = verb_length_in + 3'd1;
                     out_item.region = RG_VERB;
                  end
               end
               PH_ARG_LEAD: begin
                  if (in_item.blank) out_item.region = RG_BLANK;
                  else begin
                     phase_in = PH_ARG;
                     out_item.region = RG_ARG;
                  end
               end
               PH_ARG: out_item.region = RG_ARG;
               PH_FIELDS: begin
                  if (in_item.blank) begin
                     out_item.region = (inside_field_in || field_total_in < lim) ?
                                       RG_BLANK : RG_IGN;
                     inside_field_in = 1'b0;
                  end else if (!inside_field_in && field_total_in >= lim) begin
                     out_item.region = RG_IGN;
                  end else begin
                     if (!inside_field_in) begin
                        fv1_in = fv0_in;
                        ok1_in = ok0_in;
                        fv0_in = '0;
                        ok0_in = 1'b1;
                        field_total_in = field_total_in + 3'd1;
                        inside_field_in = 1'b1;
                     end
                     // value*10 + digit; any carry above the count width is overflow
                     prod = (COUNT_WIDTH+4)'({fv0_in, 3'b000}) +
                            (COUNT_WIDTH+4)'({fv0_in, 1'b0}) +
                            (COUNT_WIDTH+4)'(in_item.data[3:0]);
                     if (in_item.digit && ok0_in) begin
                        if (prod[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0) ok0_in = 1'b0;
                        else fv0_in = prod[COUNT_WIDTH-1:0];
                     end else begin
                        ok0_in = 1'b0;
                     end
                     out_item.region = RG_FIELD;
                     out_item.field_number = field_total_in - 3'd1;
                  end
               end
               default: out_item.region = RG_IGN;
            endcase
            out_item.op_code = op_in;
         end
      end

      if (body_out) begin
         fv0_x = EW'(fv0_in);
         fv1_x = EW'(fv1_in);
         out_item.op_code = OP_MSG;
         out_item.has_reply = (field_total_in == lim);
         out_item.has_headers = (verb_length_in == 3'd4);
         out_item.hdr_count = fv1_x[31:0];
         out_item.payload_bytes = fv0_x[31:0];
      end

      if (clear_line) begin
         phase_in = PH_VERB;
         verb_shift_in = '0;
         verb_length_in = '0;
         pending_cr_in = 1'b0;
         inside_field_in = 1'b0;
         field_total_in = '0;
         fv0_in = '0;
         fv1_in = '0;
         ok0_in = 1'b0;
         ok1_in = 1'b0;
         header_left_in = '0;
         body_left_in = '0;
         op_in = OP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERB;
         verb_shift_ff <= '0;
         verb_length_ff <= '0;
         pending_cr_ff <= 1'b0;
         inside_field_ff <= 1'b0;
         field_total_ff <= '0;
         fv0_ff <= '0;
         fv1_ff <= '0;
         ok0_ff <= 1'b0;
         ok1_ff <= 1'b0;
         header_left_ff <= '0;
         body_left_ff <= '0;
         op_ff <= OP_NONE;
      end else if (go) begin
         phase_ff <= phase_in;
         verb_shift_ff <= verb_shift_in;
         verb_length_ff <= verb_length_in;
         pending_cr_ff <= pending_cr_in;
         inside_field_ff <= inside_field_in;
         field_total_ff <= field_total_in;
         fv0_ff <= fv0_in;
         fv1_ff <= fv1_in;
         ok0_ff <= ok0_in;
         ok1_ff <= ok1_in;
         header_left_ff <= header_left_in;
         body_left_ff <= body_left_in;
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) max_payload_ff <= MAX_PAYLOAD_RST;
      else if (csr_we) max_payload_ff <= csr_wdata;
   end

`ifndef SYNTHESIS
   a_field_phase: assert property (@(posedge clock) disable iff (reset)
      inside_field_ff |-> phase_ff == PH_FIELDS)
      else $error("field open outside field phase");
   a_cr_line: assert property (@(posedge clock) disable iff (reset)
      pending_cr_ff |-> (phase_ff != PH_HEADER && phase_ff != PH_PAYLOAD &&
                         phase_ff != PH_TERM_A && phase_ff != PH_TERM_B))
      else $error("pending cr inside message body");
   a_hdr_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> header_left_ff != '0)
      else $error("header phase with nothing left");
   a_field_cnt: assert property (@(posedge clock) disable iff (reset)
      field_total_ff <= HMSG_FIELD_LIMIT)
      else $error("field count beyond limit");
`endif

endmodule

// ----- src/nats_inbound_operation_parser.sv -----
// channel   ports                              transaction
// req       req_push, req_full, req_data_byte   one received octet
// rsp       rsp_pop, rsp_empty, rsp_*           one tagged octet
// csr       csr_we, csr_wdata                   max_payload write
//
// one octet per cycle sustained while rsp_pop drains the result queue; rsp_empty
// falls once the parser writes the octet from the input queue to the result queue.
// both queues hold two transactions; the parser moves one octet per cycle whenever
// the input queue has data and the result queue has room.
// reset is synchronous and empties both queues; max_payload returns to 1048576.
module nats_inbound_operation_parser #(
   parameter int COUNT_WIDTH = nip_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_echo_byte,
   output logic [2:0]  rsp_region,
   output logic [2:0]  rsp_field_number,
   output logic        rsp_op_done,
   output logic [2:0]  rsp_op_code,
   output logic        rsp_has_reply,
   output logic        rsp_has_headers,
   output logic [31:0] rsp_hdr_count,
   output logic [31:0] rsp_payload_bytes,
   output logic        rsp_malformed,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import nip_pkg::*;

   front_item_type f_item;
   logic           f_empty, f_pop, o_full, o_push;
   rsp_item_type   o_item, r_item;

   nip_front u_front (
      .clock(clock), .reset(reset),
      .push(req_push), .data_byte(req_data_byte), .full(req_full),
      .pop(f_pop), .item(f_item), .empty(f_empty)
   );

   nip_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .in_empty(f_empty), .in_item(f_item), .in_pop(f_pop),
      .out_full(o_full), .out_push(o_push), .out_item(o_item)
   );

   nip_queue #(.item_type(rsp_item_type)) u_outq (
      .clock(clock), .reset(reset),
      .push(o_push), .push_item(o_item), .full(o_full),
      .pop(rsp_pop), .pop_item(r_item), .empty(rsp_empty)
   );

   assign rsp_echo_byte = r_item.echo_byte;
   assign rsp_region = r_item.region;
   assign rsp_field_number = r_item.field_number;
   assign rsp_op_done = r_item.op_done;
   assign rsp_op_code = r_item.op_code;
   assign rsp_has_reply = r_item.has_reply;
   assign rsp_has_headers = r_item.has_headers;
   assign rsp_hdr_count = r_item.hdr_count;
   assign rsp_payload_bytes = r_item.payload_bytes;
   assign rsp_malformed = r_item.malformed;

endmodule
